### sv/assert_macros.svh
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication on the same edge, off while reset is low.
`define AGS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, off while reset is low.
`define AGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, through reset as well.
`define AGS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ags_pkg.sv
package ags_pkg;

    localparam int GRAD_BITS   = 16;
    localparam int ROW_BITS    = 16;
    localparam int WCFG_BITS   = 12;
    localparam int CFG_BITS    = 16;

    // Q.22 product to Q5.10: add half an LSB, floor-shift by 13 (also applies the 0.5)
    localparam int ROUND_SHIFT = 13;
    localparam int ROUND_ADD   = 1 << (ROUND_SHIFT - 1);

    localparam logic [WCFG_BITS-1:0] WIDTH_RESET  = 12'd2048;
    localparam logic [ROW_BITS-1:0]  HEIGHT_RESET = 16'd2;

    // result slots of one pixel, in delivery order
    localparam int NUM_SLOTS = 3;
    localparam int SLOT_PREV = 0;   // pixel of the previous row
    localparam int SLOT_LEFT = 1;   // last-row pixel to the left
    localparam int SLOT_SELF = 2;   // last-row pixel itself (last column)
    localparam int NUM_LANES = 2 * NUM_SLOTS;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [NUM_SLOTS-1:0] t_slot_mask;

    typedef struct packed {
        logic op_en;     // load difference and sum
        logic prod_en;   // load product
    } t_lane_ctl;

endpackage

### sv/attenuated_gradient_stencil.sv
// Channel   Dir  Handshake           Beat contents
// pixel     in   i_valid / o_ready   i_log_luma, i_atten
// result    out  o_valid / i_ready   o_grad_x, o_grad_y, o_out_row, o_out_col, o_frame_end
// config    in   i_cfg_we            i_cfg_idx, i_cfg_data (taken every enabled edge)
//
// One pixel beat per cycle unless o_ready is low. Rows before the last give at most one
// result per beat; last-row pixels give two (one in column 0, three in the last column),
// one result beat per cycle unless held by i_ready. A pixel's first result passes stage 1,
// stage 2 and stage 3 into the output register; results of row r-1 stream out while row r comes in.
// Line buffers are two 1R1W RAMs read and written on the accept edge, so no forwarding.
// Reset (sync, low) clears counters, held pixels, valids and config (2048 x 2); the line
// buffers are not cleared. Output back-pressure reaches o_ready through three stages.
module attenuated_gradient_stencil #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  ags_pkg::t_cfg_reg                    i_cfg_idx,
    input  logic [ags_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [PIXEL_BITS-1:0]         i_log_luma,
    input  logic [PIXEL_BITS-1:0]                i_atten,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ags_pkg::GRAD_BITS-1:0] o_grad_x,
    output logic signed [ags_pkg::GRAD_BITS-1:0] o_grad_y,
    output logic [ags_pkg::ROW_BITS-1:0]         o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_out_col,
    output logic                                 o_frame_end
);

    import ags_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > WCFG_BITS) ? CW + 1 : WCFG_BITS;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [CW-1:0]       col;
        t_slot_mask          mask;
    } t_tag;

    // configuration
    logic [WCFG_BITS-1:0] r_width;
    logic [ROW_BITS-1:0]  r_height;
    logic [CMPW-1:0]      width_ext;
    logic [CW-1:0]        w_m1;
    logic [ROW_BITS-1:0]  h_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WCFG_BITS-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[ROW_BITS-1:0];
            endcase
        end
    end

    assign width_ext = CMPW'(r_width);

    always_comb begin
        priority if (width_ext < CMPW'(2)) begin
            w_m1 = CW'(1);
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(width_ext - CMPW'(1));
        end
        h_m1 = (r_height < ROW_BITS'(2)) ? ROW_BITS'(1) : r_height - ROW_BITS'(1);
    end

    // position of the incoming pixel
    logic [CW-1:0]       r_col;
    logic [ROW_BITS-1:0] r_row;
    logic [CW-1:0]       n_col;
    logic [ROW_BITS-1:0] n_row;
    logic [CW-1:0]       cur_col;
    logic [ROW_BITS-1:0] cur_row;
    logic                last_col;
    logic                last_row;
    t_slot_mask          in_mask;
    logic                accept;

    always_comb begin
        cur_col  = (r_col > w_m1) ? w_m1 : r_col;
        cur_row  = (r_row > h_m1) ? h_m1 : r_row;
        last_col = (cur_col == w_m1);
        last_row = (cur_row == h_m1);
        in_mask[SLOT_PREV] = (cur_row != '0);
        in_mask[SLOT_LEFT] = last_row && (cur_col != '0);
        in_mask[SLOT_SELF] = last_row && last_col;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : cur_row + ROW_BITS'(1);
        end else begin
            n_col = cur_col + CW'(1);
            n_row = cur_row;
        end
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line buffers: {luma, atten} at column c and at column c+1
    logic [2*PIXEL_BITS-1:0] rd_here;
    logic [2*PIXEL_BITS-1:0] rd_next;
    logic [2*PIXEL_BITS-1:0] wr_word;
    logic [CW-1:0]           addr_next;

    assign wr_word   = {i_log_luma, i_atten};
    assign addr_next = cur_col + CW'(1);

    ags_ram #(.WIDTH(2 * PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram_here (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (cur_col),
        .i_wdata (wr_word),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (rd_here)
    );

    ags_ram #(.WIDTH(2 * PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_ram_next (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (cur_col),
        .i_wdata (wr_word),
        .i_re    (accept),
        .i_raddr (addr_next),
        .o_rdata (rd_next)
    );

    // stage 1: line-buffer data back
    logic                  r1_v;
    t_tag                  r1_tag;
    logic                  r1_lastc;
    logic [PIXEL_BITS-1:0] r1_lum;
    logic [PIXEL_BITS-1:0] r1_att;
    logic [PIXEL_BITS-1:0] r_h0;    // prev-row luma one column left
    logic [PIXEL_BITS-1:0] r_h1;    // prev-row atten one column left
    logic [PIXEL_BITS-1:0] r_h2;    // luma of previous pixel
    logic [PIXEL_BITS-1:0] r_h3;    // atten of previous pixel
    logic [PIXEL_BITS-1:0] pl;
    logic [PIXEL_BITS-1:0] pa;
    logic [PIXEL_BITS-1:0] nl;
    logic [PIXEL_BITS-1:0] na;

    // stage 2: difference/sum, stage 3: products and result slots
    logic r2_v;
    t_tag r2_tag;
    logic r3_v;
    t_tag r3_tag;

    logic s1_go;
    logic s2_load;
    logic s2_ready;
    logic s2_go;
    logic s3_ready;
    logic s3_last;
    logic emit;
    logic out_free;

    assign {pl, pa} = rd_here;
    assign {nl, na} = rd_next;

    always_comb begin
        out_free = !o_valid || i_ready;
        emit     = r3_v && out_free;
        s3_ready = !r3_v || (out_free && s3_last);
        s2_go    = r2_v && s3_ready;
        s2_ready = !r2_v || s3_ready;
        s1_go    = r1_v && ((r1_tag.mask == '0) || s2_ready);
        s2_load  = s1_go && (r1_tag.mask != '0);
        o_ready  = !r1_v || s1_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (accept) begin
            r1_v <= 1'b1;
        end else if (s1_go) begin
            r1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_tag   <= '{row: cur_row, col: cur_col, mask: in_mask};
            r1_lastc <= last_col;
            r1_lum   <= i_log_luma;
            r1_att   <= i_atten;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0 <= '0;
            r_h1 <= '0;
            r_h2 <= '0;
            r_h3 <= '0;
        end else if (s1_go) begin
            r_h0 <= pl;
            r_h1 <= pa;
            r_h2 <= r1_lum;
            r_h3 <= r1_att;
        end
    end

    // lane operands: lane 2*slot is grad_x, lane 2*slot+1 is grad_y
    logic [PIXEL_BITS-1:0]        op_l_nb   [NUM_LANES];
    logic [PIXEL_BITS-1:0]        op_l_self [NUM_LANES];
    logic [PIXEL_BITS-1:0]        op_a_nb   [NUM_LANES];
    logic [PIXEL_BITS-1:0]        op_a_self [NUM_LANES];
    logic signed [GRAD_BITS-1:0]  lane_grad [NUM_LANES];
    t_lane_ctl                    lane_ctl;

    always_comb begin
        // previous row: right neighbor, or the held left one in the last column
        op_l_nb[2*SLOT_PREV]     = r1_lastc ? r_h0 : nl;
        op_l_self[2*SLOT_PREV]   = pl;
        op_a_nb[2*SLOT_PREV]     = r1_lastc ? r_h1 : na;
        op_a_self[2*SLOT_PREV]   = pa;
        op_l_nb[2*SLOT_PREV+1]   = r1_lum;
        op_l_self[2*SLOT_PREV+1] = pl;
        op_a_nb[2*SLOT_PREV+1]   = r1_att;
        op_a_self[2*SLOT_PREV+1] = pa;
        // last row, pixel to the left; row above stands in below it
        op_l_nb[2*SLOT_LEFT]     = r1_lum;
        op_l_self[2*SLOT_LEFT]   = r_h2;
        op_a_nb[2*SLOT_LEFT]     = r1_att;
        op_a_self[2*SLOT_LEFT]   = r_h3;
        op_l_nb[2*SLOT_LEFT+1]   = r_h0;
        op_l_self[2*SLOT_LEFT+1] = r_h2;
        op_a_nb[2*SLOT_LEFT+1]   = r_h1;
        op_a_self[2*SLOT_LEFT+1] = r_h3;
        // last row, last column
        op_l_nb[2*SLOT_SELF]     = r_h2;
        op_l_self[2*SLOT_SELF]   = r1_lum;
        op_a_nb[2*SLOT_SELF]     = r_h3;
        op_a_self[2*SLOT_SELF]   = r1_att;
        op_l_nb[2*SLOT_SELF+1]   = pl;
        op_l_self[2*SLOT_SELF+1] = r1_lum;
        op_a_nb[2*SLOT_SELF+1]   = pa;
        op_a_self[2*SLOT_SELF+1] = r1_att;

        lane_ctl.op_en   = s2_load;
        lane_ctl.prod_en = s2_go;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        ags_lane #(.PIXEL_BITS(PIXEL_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_l_nb   (op_l_nb[g]),
            .i_l_self (op_l_self[g]),
            .i_a_nb   (op_a_nb[g]),
            .i_a_self (op_a_self[g]),
            .o_grad   (lane_grad[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (s2_load) begin
            r2_v <= 1'b1;
        end else if (s2_go) begin
            r2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r2_tag <= r1_tag;
        end
    end

    // stage 3 hands out its slots one beat at a time, lowest slot first
    t_slot_mask                  pick;
    t_slot_mask                  n_mask;
    logic signed [GRAD_BITS-1:0] n_grad_x;
    logic signed [GRAD_BITS-1:0] n_grad_y;
    logic [ROW_BITS-1:0]         n_out_row;
    logic [CW-1:0]               n_out_col;
    logic                        n_frame_end;

    always_comb begin
        pick = '0;
        priority if (r3_tag.mask[SLOT_PREV]) begin
            pick[SLOT_PREV] = 1'b1;
            n_grad_x    = lane_grad[2*SLOT_PREV];
            n_grad_y    = lane_grad[2*SLOT_PREV+1];
            n_out_row   = r3_tag.row - ROW_BITS'(1);
            n_out_col   = r3_tag.col;
            n_frame_end = 1'b0;
        end else if (r3_tag.mask[SLOT_LEFT]) begin
            pick[SLOT_LEFT] = 1'b1;
            n_grad_x    = lane_grad[2*SLOT_LEFT];
            n_grad_y    = lane_grad[2*SLOT_LEFT+1];
            n_out_row   = r3_tag.row;
            n_out_col   = r3_tag.col - CW'(1);
            n_frame_end = 1'b0;
        end else begin
            pick[SLOT_SELF] = 1'b1;
            n_grad_x    = lane_grad[2*SLOT_SELF];
            n_grad_y    = lane_grad[2*SLOT_SELF+1];
            n_out_row   = r3_tag.row;
            n_out_col   = r3_tag.col;
            n_frame_end = 1'b1;
        end
        n_mask  = r3_tag.mask & ~pick;
        s3_last = (n_mask == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (s2_go) begin
            r3_v <= 1'b1;
        end else if (emit && s3_last) begin
            r3_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r3_tag <= r2_tag;
        end else if (emit) begin
            r3_tag.mask <= n_mask;
        end
    end

    // output register
    logic                        r_ov;
    logic signed [GRAD_BITS-1:0] r_grad_x;
    logic signed [GRAD_BITS-1:0] r_grad_y;
    logic [ROW_BITS-1:0]         r_out_row;
    logic [CW-1:0]               r_out_col;
    logic                        r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_grad_x    <= n_grad_x;
            r_grad_y    <= n_grad_y;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_frame_end <= n_frame_end;
        end
    end

    assign o_valid     = r_ov;
    assign o_grad_x    = r_grad_x;
    assign o_grad_y    = r_grad_y;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_frame_end = r_frame_end;

endmodule

### sv/ags_ram.sv
module ags_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when the same entry is written on that edge
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ags_lane.sv
module ags_lane #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                 i_clk,
    input  ags_pkg::t_lane_ctl                   i_ctl,
    input  logic [PIXEL_BITS-1:0]                i_l_nb,
    input  logic [PIXEL_BITS-1:0]                i_l_self,
    input  logic [PIXEL_BITS-1:0]                i_a_nb,
    input  logic [PIXEL_BITS-1:0]                i_a_self,
    output logic signed [ags_pkg::GRAD_BITS-1:0] o_grad
);

    import ags_pkg::*;

    localparam int DW = PIXEL_BITS + 2;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] r_d;
    logic signed [DW-1:0] r_s;
    logic signed [PW-1:0] r_p;
    logic signed [DW-1:0] n_d;
    logic signed [DW-1:0] n_s;
    logic signed [PW-1:0] n_p;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] quo;
    logic                 fits;

    always_comb begin
        n_d = $signed({{2{i_l_nb[PIXEL_BITS-1]}}, i_l_nb})
            - $signed({{2{i_l_self[PIXEL_BITS-1]}}, i_l_self});
        n_s = $signed({2'b00, i_a_nb}) + $signed({2'b00, i_a_self});
        n_p = r_d * r_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op_en) begin
            r_d <= n_d;
            r_s <= n_s;
        end
        if (i_ctl.prod_en) begin
            r_p <= n_p;
        end
    end

    // round half up, floor shift, saturate
    assign rnd  = r_p + PW'(ROUND_ADD);
    assign quo  = rnd >>> ROUND_SHIFT;
    assign fits = (&quo[PW-1:GRAD_BITS-1]) || !(|quo[PW-1:GRAD_BITS-1]);

    always_comb begin
        if (fits) begin
            o_grad = $signed(quo[GRAD_BITS-1:0]);
        end else if (quo[PW-1]) begin
            o_grad = $signed({1'b1, {(GRAD_BITS-1){1'b0}}});
        end else begin
            o_grad = $signed({1'b0, {(GRAD_BITS-1){1'b1}}});
        end
    end

endmodule

### sv/ags_chk.sv
`include "assert_macros.svh"

module ags_chk #(
    parameter int MAX_WIDTH = 2048
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [15:0]                  o_grad_x,
    input logic [15:0]                  o_grad_y,
    input logic [15:0]                  o_out_row,
    input logic [$clog2(MAX_WIDTH)-1:0] o_out_col,
    input logic                         o_frame_end
);

    // whole pipeline empties on reset
    `AGS_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid && o_ready, "not idle after reset")

    // stalled result beat holds
    `AGS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_grad_x) && $stable(o_grad_y) && $stable(o_out_row) && $stable(o_out_col) && $stable(o_frame_end), "result beat changed while stalled")

    // the frame's final pixel is never in row 0 or column 0
    `AGS_ASSERT_NOW(a_frame_end_pos, i_clk, i_rst_n, o_valid && o_frame_end, (o_out_row != '0) && (o_out_col != '0), "frame end on first row or column")

endmodule

bind attenuated_gradient_stencil ags_chk #(.MAX_WIDTH(MAX_WIDTH)) u_ags_chk (.*);

### sim/stencil_checker.sv
`timescale 1ns / 100ps

module stencil_checker #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  ags_pkg::t_cfg_reg i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_pix_valid,
    input  logic              i_pix_ready,
    input  logic [15:0]       i_log_luma,
    input  logic [15:0]       i_atten,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [15:0]       i_grad_x,
    input  logic [15:0]       i_grad_y,
    input  logic [15:0]       i_out_row,
    input  logic [10:0]       i_out_col,
    input  logic              i_frame_end,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_next_col,
    output int                o_next_row
);
    import ags_pkg::*;

    localparam longint HALF_LSB   = 4096;
    localparam int     GRAD_SHIFT = 13;

    typedef struct packed {
        logic [15:0] grad_x;
        logic [15:0] grad_y;
        logic [15:0] row;
        logic [10:0] col;
        logic        frame_end;
    } t_grad_beat;

    logic [15:0] line_luma  [MAX_WIDTH];
    logic [15:0] line_atten [MAX_WIDTH];
    // pixel above-left (line buffer entry before it was overwritten) and pixel to the left
    logic [15:0] upleft_luma, upleft_atten;
    logic [15:0] left_luma, left_atten;
    int          col_pos, row_pos;
    int          width_reg  = 2048;
    int          height_reg = 2;
    int          err_total  = 0;
    t_grad_beat  pending_grads[$];

    // (l_nb - l_self) * (a_nb + a_self) / 2, Q5.10, round half up, saturate
    function automatic logic [15:0] atten_diff(input logic [15:0] l_nb,
                                               input logic [15:0] l_self,
                                               input logic [15:0] a_nb,
                                               input logic [15:0] a_self);
        longint diff;
        longint prod;
        diff = longint'($signed(l_nb)) - longint'($signed(l_self));
        prod = diff * (longint'(a_nb) + longint'(a_self)) + HALF_LSB;
        prod = prod >>> GRAD_SHIFT;
        if (prod > 32767) prod = 32767;
        if (prod < -32768) prod = -32768;
        return prod[15:0];
    endfunction

    function automatic t_grad_beat grad_beat(input logic [15:0] gx, input logic [15:0] gy,
                                             input int row, input int col, input logic fe);
        t_grad_beat beat;
        beat.grad_x    = gx;
        beat.grad_y    = gy;
        beat.row       = row[15:0];
        beat.col       = col[10:0];
        beat.frame_end = fe;
        return beat;
    endfunction

    task automatic enqueue_grad(input t_grad_beat beat);
        pending_grads.insert(pending_grads.size(), beat);
    endtask

    task automatic predict_gradients(input logic [15:0] lum, input logic [15:0] att);
        int          w, h, c, r;
        logic        last_col, last_row;
        logic [15:0] pl, pa, gx;
        w = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
        h = height_reg < 2 ? 2 : height_reg;
        // counters past a lowered size land on the last column / row
        c = col_pos < w ? col_pos : w - 1;
        r = row_pos < h ? row_pos : h - 1;
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        pl = line_luma[c];
        pa = line_atten[c];

        if (r >= 1) begin
            if (last_col)
                gx = atten_diff(upleft_luma, pl, upleft_atten, pa);
            else
                gx = atten_diff(line_luma[c + 1], pl, line_atten[c + 1], pa);
            enqueue_grad(grad_beat(gx, atten_diff(lum, pl, att, pa), r - 1, c, 1'b0));
        end
        if (last_row && c >= 1) begin
            enqueue_grad(grad_beat(
                atten_diff(lum, left_luma, att, left_atten),
                atten_diff(upleft_luma, left_luma, upleft_atten, left_atten),
                r, c - 1, 1'b0));
        end
        if (last_row && last_col) begin
            enqueue_grad(grad_beat(
                atten_diff(left_luma, lum, left_atten, att),
                atten_diff(pl, lum, pa, att),
                r, c, 1'b1));
        end

        upleft_luma   = pl;
        upleft_atten  = pa;
        left_luma     = lum;
        left_atten    = att;
        line_luma[c]  = lum;
        line_atten[c] = att;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%h, got 0x%h", $time, name, want, got);
            err_total++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_grad_beat want;
        if (!i_rst_n) begin
            width_reg    = 2048;
            height_reg   = 2;
            col_pos      = 0;
            row_pos      = 0;
            upleft_luma  = '0;
            upleft_atten = '0;
            left_luma    = '0;
            left_atten   = '0;
            err_total    = 0;
            pending_grads.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMAGE_WIDTH:  width_reg = i_cfg_data[11:0];
                    REG_IMAGE_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            // retire the result beat first: it cannot stem from this edge's pixel
            if (i_res_valid && i_res_ready) begin
                if (pending_grads.size() == 0) begin
                    $display("%0t: result with nothing expected, row %0d col %0d", $time,
                             i_out_row, i_out_col);
                    err_total++;
                end else begin
                    want = pending_grads.pop_front();
                    compare_field("grad_x", want.grad_x, i_grad_x);
                    compare_field("grad_y", want.grad_y, i_grad_y);
                    compare_field("out_row", want.row, i_out_row);
                    compare_field("out_col", 16'(want.col), 16'(i_out_col));
                    compare_field("frame_end", 16'(want.frame_end), 16'(i_frame_end));
                end
            end
            if (i_pix_valid && i_pix_ready)
                predict_gradients(i_log_luma, i_atten);
        end
        o_fail_count <= err_total;
        o_pending    <= pending_grads.size();
        o_next_col   <= col_pos;
        o_next_row   <= row_pos;
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ags_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PIXELS = 400;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    t_cfg_reg           cfg_idx   = REG_IMAGE_WIDTH;
    logic [15:0]        cfg_data  = '0;
    logic               pix_valid = 1'b0;
    logic               pix_ready;
    logic signed [15:0] log_luma  = '0;
    logic [15:0]        atten     = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic signed [15:0] grad_x, grad_y;
    logic [15:0]        out_row;
    logic [10:0]        out_col;
    logic               frame_end;

    int fail_count, grads_pending, next_col, next_row;
    int cur_w       = 2048;
    int cur_h       = 2;
    int idle_cycles = 0;
    bit calm        = 1'b0;
    bit gentle      = 1'b0;

    logic [15:0] corner_luma [9] = '{16'h0000, 16'hffff, 16'h0001, 16'h0064, 16'hff9c,
                                     16'h7fff, 16'h8000, 16'h0005, 16'h0000};
    logic [15:0] corner_atten[9] = '{16'h1000, 16'h0000, 16'hffff, 16'h1000, 16'h2000,
                                     16'h0001, 16'hffff, 16'h0000, 16'h1000};

    attenuated_gradient_stencil u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_valid     (pix_valid),
        .o_ready     (pix_ready),
        .i_log_luma  (log_luma),
        .i_atten     (atten),
        .o_valid     (res_valid),
        .i_ready     (res_ready),
        .o_grad_x    (grad_x),
        .o_grad_y    (grad_y),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_frame_end (frame_end)
    );

    stencil_checker #(.MAX_WIDTH(MAX_W)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .i_log_luma   (log_luma),
        .i_atten      (atten),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_grad_x     (grad_x),
        .i_grad_y     (grad_y),
        .i_out_row    (out_row),
        .i_out_col    (out_col),
        .i_frame_end  (frame_end),
        .o_fail_count (fail_count),
        .o_pending    (grads_pending),
        .o_next_col   (next_col),
        .o_next_row   (next_row)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_luma();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return 16'h8000;
        if (roll < 8) return 16'h7fff;
        if (roll < 10) return 16'h0000;
        if (gentle) return 16'($urandom_range(0, 4095)) - 16'd2048;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_atten();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return 16'hffff;
        if (roll < 8) return 16'h0000;
        if (gentle) return 16'($urandom_range(0, 12288));
        return 16'($urandom);
    endfunction

    function automatic int pixels_to_frame_end();
        int c, r;
        c = next_col < cur_w ? next_col : cur_w - 1;
        r = next_row < cur_h ? next_row : cur_h - 1;
        return (cur_h - 1 - r) * cur_w + (cur_w - c);
    endfunction

    initial begin : result_sink
        int on_len, gap;
        forever begin
            res_ready <= 1'b1;
            on_len = $urandom_range(1, 24);
            repeat (on_len) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((pix_valid && pix_ready) || (res_valid && res_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                         idle_cycles, grads_pending);
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic push_pixel(input logic [15:0] lum, input logic [15:0] att);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        log_luma  <= lum;
        atten     <= att;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
    endtask

    // first-row pixels give no result, so also settle for SETTLE_CYCLES once nothing is pending
    task automatic wait_drained();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (grads_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input int raw_w, input int raw_h);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_IMAGE_WIDTH;
        cfg_data <= 16'(raw_w);
        @(posedge clk);
        cfg_idx  <= REG_IMAGE_HEIGHT;
        cfg_data <= 16'(raw_h);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_w = raw_w < 2 ? 2 : (raw_w > MAX_W ? MAX_W : raw_w);
        cur_h = raw_h < 2 ? 2 : raw_h;
    endtask

    initial begin : stimulus
        int random_sent, roll, new_w, new_h, raw_w, raw_h, left, count;
        bit at_origin;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sizes below range saturate to 2x2; full-scale pixels saturate the gradients
        set_size(1, 0);
        push_pixel(16'h7fff, 16'hffff);
        push_pixel(16'h8000, 16'hffff);
        push_pixel(16'h8000, 16'h0000);
        push_pixel(16'h7fff, 16'hffff);
        wait_drained();

        set_size(3, 3);
        for (int i = 0; i < 9; i++) push_pixel(corner_luma[i], corner_atten[i]);
        wait_drained();

        // stop at row 1 col 3 of a 4x3 frame, then shrink to 2x2: the next pixel
        // is taken as the last column of the last row and closes the frame
        set_size(4, 3);
        repeat (7) push_pixel(pick_luma(), pick_atten());
        wait_drained();
        set_size(2, 2);
        push_pixel(pick_luma(), pick_atten());
        wait_drained();

        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            at_origin = (next_col == 0 && next_row == 0);
            roll = $urandom_range(0, 99);
            if (roll < 6) new_w = MAX_W;
            else if (roll < 22) new_w = 2;
            else new_w = $urandom_range(3, 12);
            // width may only grow at a frame boundary, or stale line entries get read
            if (!at_origin && new_w > cur_w) new_w = cur_w;
            roll = $urandom_range(0, 99);
            if (roll < 6) new_h = 65535;
            else if (roll < 18) new_h = 2;
            else new_h = $urandom_range(3, 6);

            if (new_w == 2) raw_w = $urandom_range(0, 2);
            else if (new_w == MAX_W) raw_w = $urandom_range(MAX_W, 4095);
            else raw_w = new_w;
            raw_h = (new_h == 2) ? $urandom_range(0, 2) : new_h;
            set_size(raw_w, raw_h);

            left = pixels_to_frame_end();
            if (left <= 150 && $urandom_range(0, 99) < 75) count = left;
            else count = $urandom_range(1, left < 60 ? left : 60);
            gentle = $urandom_range(0, 1);
            calm   = ($urandom_range(0, 4) == 0);
            repeat (count) push_pixel(pick_luma(), pick_atten());
            random_sent += count;
            wait_drained();
        end

        if (fail_count == 0 && grads_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
